[rtl/acpaft_pkg.sv]
// package for the ac phase-angle firing timer
// holds defaults, register index codes and the equal-area firing delay table
// no dependencies
package acpaft_pkg;

   // field widths
   localparam int LEVEL_W     = 7;
   localparam int DELAY_W     = 14;
   localparam int TIME_W      = 16;
   localparam int MARGIN_W    = 10;
   localparam int TABLE_SIZE  = 128;

   // parameter defaults
   localparam int LEVEL_COUNT_DEF = 128;
   localparam int COUNT_WIDTH_DEF = 16;

   // register reset values
   localparam logic [TIME_W-1:0]   LOCKOUT_RST = 16'd12500;
   localparam logic [TIME_W-1:0]   PERIOD_RST  = 16'd16667;
   localparam logic [MARGIN_W-1:0] MARGIN_RST  = 10'd100;

   // largest power level
   localparam logic [LEVEL_W-1:0] MAX_LEVEL = 7'd127;

   // register index codes
   typedef enum logic [1:0] {
      CSR_LOCKOUT = 2'd0,
      CSR_PERIOD  = 2'd1,
      CSR_MARGIN  = 2'd2
   } csr_index_type;

   typedef logic [DELAY_W-1:0] delay_type;

   // firing delay in ticks per level, equal conducted area per step
   localparam delay_type DELAY_ROM [TABLE_SIZE] = '{
      14'd8333, 14'd7862, 14'd7666, 14'd7515, 14'd7387, 14'd7274, 14'd7171, 14'd7076,
      14'd6987, 14'd6904, 14'd6824, 14'd6749, 14'd6676, 14'd6606, 14'd6538, 14'd6472,
      14'd6408, 14'd6346, 14'd6286, 14'd6226, 14'd6168, 14'd6112, 14'd6056, 14'd6001,
      14'd5947, 14'd5895, 14'd5842, 14'd5791, 14'd5740, 14'd5690, 14'd5641, 14'd5592,
      14'd5544, 14'd5496, 14'd5448, 14'd5401, 14'd5355, 14'd5309, 14'd5263, 14'd5217,
      14'd5172, 14'd5127, 14'd5083, 14'd5039, 14'd4995, 14'd4951, 14'd4907, 14'd4864,
      14'd4821, 14'd4778, 14'd4735, 14'd4692, 14'd4650, 14'd4607, 14'd4565, 14'd4523,
      14'd4481, 14'd4439, 14'd4397, 14'd4355, 14'd4313, 14'd4271, 14'd4229, 14'd4188,
      14'd4146, 14'd4104, 14'd4062, 14'd4020, 14'd3979, 14'd3937, 14'd3895, 14'd3853,
      14'd3811, 14'd3768, 14'd3726, 14'd3684, 14'd3641, 14'd3598, 14'd3556, 14'd3513,
      14'd3469, 14'd3426, 14'd3382, 14'd3339, 14'd3295, 14'd3250, 14'd3206, 14'd3161,
      14'd3116, 14'd3071, 14'd3025, 14'd2979, 14'd2932, 14'd2885, 14'd2838, 14'd2790,
      14'd2741, 14'd2693, 14'd2643, 14'd2593, 14'd2542, 14'd2491, 14'd2439, 14'd2386,
      14'd2332, 14'd2277, 14'd2222, 14'd2165, 14'd2107, 14'd2048, 14'd1987, 14'd1925,
      14'd1861, 14'd1795, 14'd1728, 14'd1658, 14'd1585, 14'd1509, 14'd1430, 14'd1346,
      14'd1257, 14'd1162, 14'd1060, 14'd947,  14'd819,  14'd668,  14'd471,  14'd0
   };

endpackage

[rtl/ac_phase_angle_firing_timer_top.sv]
// Phase-angle firing timer for an ac load switch. One req beat is one microsecond
// tick and yields exactly one rsp beat; a new beat is taken every cycle (one tick
// per cycle sustained) while rsp_tready holds. The first register stage reads the
// firing delay table through its registered port, the second updates the
// elapsed counter, arming and switch state. A zero crossing is taken only once
// the elapsed count exceeds the lockout; the switch turns on when the count
// reaches the latched delay and off when it equals the lockout. The rsp stage is
// a register; while a result waits to be taken, stage 1 can still take one more
// req beat, then req_tready drops until the waiting result leaves.
// Depends on acpaft_pkg.
module ac_phase_angle_firing_timer_top
   import acpaft_pkg::*;
#(
   parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] zero_cross_seen, [8:1] duty_request, [15:9] zero
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] switch_on, [1] ac_present,
                                    // [8:2] applied_level, [9] crossing_accepted,
                                    // [15:10] zero
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // largest table index reachable
   localparam int IDX_CAP_I = (LEVEL_COUNT - 1 < TABLE_SIZE - 1) ?
                              (LEVEL_COUNT - 1) : (TABLE_SIZE - 1);
   localparam logic [LEVEL_W-1:0] IDX_CAP = LEVEL_W'(IDX_CAP_I);
   // compare width covers counter and period plus margin
   localparam int CMP_W = (COUNT_WIDTH > TIME_W + 1) ? COUNT_WIDTH : (TIME_W + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [TIME_W-1:0]   lockout_ff;
   logic [TIME_W-1:0]   period_ff;
   logic [MARGIN_W-1:0] margin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RST;
         period_ff  <= PERIOD_RST;
         margin_ff  <= MARGIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOCKOUT: lockout_ff <= csr_data;
            CSR_PERIOD:  period_ff  <= csr_data;
            CSR_MARGIN:  margin_ff  <= csr_data[MARGIN_W-1:0];
            default:     ;
         endcase
      end
   end

   // pipeline flow control
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (advance)    rsp_valid_ff <= s1_valid_ff;
      end
   end

   // input clip and table address
   logic [7:0]         duty_in;
   logic [LEVEL_W-1:0] level_in;
   logic [LEVEL_W-1:0] rom_addr;

   assign duty_in  = req_tdata[8:1];
   assign level_in = (duty_in > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : duty_in[LEVEL_W-1:0];
   assign rom_addr = (level_in > IDX_CAP) ? IDX_CAP : level_in;

   // stage 1: registered table read and item payload
   logic               s1_zc_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   delay_type          s1_delay_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_zc_ff    <= req_tdata[0];
         s1_level_ff <= level_in;
         s1_delay_ff <= DELAY_ROM[rom_addr];
      end
   end

   // tick state
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   delay_type              delay_ff, delay_in;
   logic                   armed_ff, armed_in;
   logic                   switch_ff, switch_in;

   logic [COUNT_WIDTH-1:0] elapsed_inc;
   logic [CMP_W-1:0]       elapsed_x;
   logic [CMP_W-1:0]       elapsed_inc_x;
   logic [CMP_W-1:0]       lockout_x;
   logic [CMP_W-1:0]       hot_limit_x;
   logic                   accepted;
   logic                   present;

   // stage 2: counter, crossing, firing and off logic
   always_comb begin
      elapsed_inc   = (elapsed_ff != COUNT_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      elapsed_inc_x = CMP_W'(elapsed_inc);
      lockout_x     = CMP_W'(lockout_ff);
      hot_limit_x   = CMP_W'({1'b0, period_ff} + {{(TIME_W + 1 - MARGIN_W){1'b0}}, margin_ff});
      accepted      = s1_zc_ff && (elapsed_inc_x > lockout_x);
      elapsed_in    = accepted ? '0 : elapsed_inc;
      delay_in      = delay_ff;
      armed_in      = armed_ff;
      switch_in     = switch_ff;
      if (accepted) begin
         if (s1_level_ff != '0) begin
            delay_in = s1_delay_ff;
            armed_in = 1'b1;
         end else begin
            armed_in = 1'b0;
         end
      end
      elapsed_x = CMP_W'(elapsed_in);
      if (armed_in && (elapsed_x >= CMP_W'(delay_in))) begin
         switch_in = 1'b1;
         armed_in  = 1'b0;
      end
      if (elapsed_x == lockout_x) switch_in = 1'b0;
      present = elapsed_x < hot_limit_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         delay_ff   <= '0;
         armed_ff   <= 1'b0;
         switch_ff  <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         elapsed_ff <= elapsed_in;
         delay_ff   <= delay_in;
         armed_ff   <= armed_in;
         switch_ff  <= switch_in;
      end
   end

   // result register
   logic [15:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         rsp_data_ff <= {6'd0, accepted, s1_level_ff, present, switch_in};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
